// ===== design/xsf_pkg.sv =====
package xsf_pkg;

	// sprite geometry
	localparam int SPRITE_PIXELS = 8;

	// operation codes
	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// register map, index is paddr[2]
	localparam int         CFG_ADDR_W        = 3;
	localparam logic       REG_ACTIVE_WIDTH  = 1'b0;
	localparam logic       REG_ACTIVE_HEIGHT = 1'b1;
	localparam logic [6:0] ACTIVE_WIDTH_RST  = 7'd64;
	localparam logic [5:0] ACTIVE_HEIGHT_RST = 6'd32;

	typedef struct packed {
		logic [6:0] active_width;
		logic [5:0] active_height;
	} cfg_t;

endpackage

// ===== design/xor_sprite_framebuffer.sv =====
// xor sprite framebuffer: monochrome frame of MAX_HEIGHT rows by MAX_WIDTH columns
//
// input channel s_*: one item per operation, opcode in s_tuser (draw, clear, read)
// output channel m_*: exactly one result item per input item, in order
//   draw  - xor an 8-pixel sprite row into one frame row, collision if a lit pixel
//           goes dark, columns past the active width are clipped
//   clear - blanks the whole frame (per-row valid bits are dropped)
//   read  - returns the row in m_tdata, bit k is column k, clipped to the width
//   a draw or read on a row at or past the active height sets skipped
// pipeline: the row memory is read at the accepting edge, the update stage then forms the
//   row update, and the result register behind it drives m_tvalid
// throughput: one item per cycle while m_tready is high; a write-back in the update
//   stage is forwarded to the following item when it hits the same row
// stall: the result register holds while m_tready is low, and the update stage holds
//   behind it once it is full; s_tready drops only once both are full
// reset: arst_n clears all row valid bits, so the frame reads as blank, and
//   loads active_width 64, active_height 32; no clearing pass is needed
// apb: active_width at 0x0, active_height at 0x4, write only while idle
module xor_sprite_framebuffer #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,  // start_column, row_index, sprite_bits
	input  logic [1:0]                     s_tuser,  // opcode
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [63:0]                    m_tdata,  // row_pixels
	output logic [1:0]                     m_tuser,  // collision, skipped
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [xsf_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	xsf_pkg::cfg_t cfg;

	// input handshake
	logic accept;
	logic s1_adv;

	// update stage
	logic        s1_valid;
	logic [1:0]  s1_op;
	logic [7:0]  s1_col;
	logic [7:0]  s1_row;
	logic [7:0]  s1_spr;
	logic [AW-1:0] s1_addr;

	// row store
	logic [MAX_WIDTH-1:0]  ram_rdata;
	logic [MAX_HEIGHT-1:0] row_valid_q;
	logic                  byp_valid_q;
	logic [AW-1:0]         byp_addr_q;
	logic [MAX_WIDTH-1:0]  byp_data_q;
	logic [MAX_WIDTH-1:0]  cur_row;
	logic                  wr_en;

	// effective size
	logic [6:0] eff_w;
	logic [6:0] eff_h;
	logic       row_out;

	// row datapath
	logic [MAX_WIDTH-1:0] new_row;
	logic [MAX_WIDTH-1:0] masked_row;
	logic                 hit;
	logic                 draw_coll;

	// result
	logic        res_coll;
	logic        res_skip;
	logic [63:0] res_pix;
	logic        out_valid_q;
	logic        out_coll_q;
	logic        out_skip_q;
	logic [63:0] out_pix_q;

	xsf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage advances when the result register is free or being emptied
	assign s1_adv   = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || s1_adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_op  <= s_tuser;
			s1_col <= s_tdata[7:0];
			s1_row <= s_tdata[15:8];
			s1_spr <= s_tdata[23:16];
		end
	end

	assign s1_addr = s1_row[AW-1:0];

	// row memory is read as the item enters, written back from the update stage
	xsf_ram #(
		.WIDTH (MAX_WIDTH),
		.DEPTH (MAX_HEIGHT)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (s1_addr),
		.wdata (new_row),
		.re    (accept),
		.raddr (s_tdata[AW+7:8]),
		.rdata (ram_rdata)
	);

	// clamp the programmed size to what the store holds
	assign eff_w = (cfg.active_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : cfg.active_width;
	assign eff_h = ({1'b0, cfg.active_height} > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT)
		: {1'b0, cfg.active_height};
	assign row_out = s1_row >= {1'b0, eff_h};

	// the write at the edge that issued our read missed the memory output
	assign hit     = byp_valid_q && (byp_addr_q == s1_addr);
	assign cur_row = hit ? byp_data_q : (row_valid_q[s1_addr] ? ram_rdata : '0);

	xsf_row #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_row (
		.row          (cur_row),
		.start_column (s1_col),
		.sprite_bits  (s1_spr),
		.eff_width    (eff_w),
		.new_row      (new_row),
		.masked_row   (masked_row),
		.collision    (draw_coll)
	);

	assign wr_en = s1_adv && (s1_op == xsf_pkg::OP_DRAW) && !row_out;

	always_comb begin
		res_coll = 1'b0;
		res_skip = 1'b0;
		res_pix  = '0;
		unique case (s1_op)
			xsf_pkg::OP_DRAW: begin
				res_skip = row_out;
				res_coll = !row_out && draw_coll;
			end
			xsf_pkg::OP_READ: begin
				res_skip = row_out;
				res_pix  = row_out ? 64'd0 : 64'(masked_row);
			end
			default: ;
		endcase
	end

	// per-row valid bits: a row never written since reset or clear reads blank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (s1_adv && (s1_op == xsf_pkg::OP_CLEAR)) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[s1_addr] <= 1'b1;
		end
	end

	// forwarding entry, live only while the item that needs it sits in the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (accept) begin
			byp_valid_q <= wr_en;
		end else if (s1_adv) begin
			byp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byp_addr_q <= s1_addr;
			byp_data_q <= new_row;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_coll_q <= res_coll;
			out_skip_q <= res_skip;
			out_pix_q  <= res_pix;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tuser  = {out_skip_q, out_coll_q};

`ifndef SYNTHESIS
	// a skipped row never reports a collision
	a_skip_no_coll: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("collision reported on a skipped row");

	// skipped and colliding draw results carry no pixels
	a_skip_no_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == 64'd0))
		else $error("pixels returned on a skipped row");

	a_coll_no_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0))
		else $error("pixels returned with a draw result");

	// forwarding entry only lives alongside an item in the update stage
	a_byp_owner: assert property (@(posedge clk) disable iff (!arst_n)
		byp_valid_q |-> s1_valid)
		else $error("forwarding entry live with the update stage empty");

	// a write-back always sets its row valid
	a_wr_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> row_valid_q[$past(s1_addr)])
		else $error("written row not marked valid");
`endif

endmodule

// ===== design/xsf_ram.sv =====
module xsf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// old data on a same-address collision
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/xsf_cfg.sv =====
module xsf_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [xsf_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output xsf_pkg::cfg_t                     cfg
);

	xsf_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_width  <= xsf_pkg::ACTIVE_WIDTH_RST;
			cfg_q.active_height <= xsf_pkg::ACTIVE_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				xsf_pkg::REG_ACTIVE_WIDTH:  cfg_q.active_width  <= pwdata[6:0];
				xsf_pkg::REG_ACTIVE_HEIGHT: cfg_q.active_height <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			xsf_pkg::REG_ACTIVE_WIDTH:  prdata = 32'(cfg_q.active_width);
			xsf_pkg::REG_ACTIVE_HEIGHT: prdata = 32'(cfg_q.active_height);
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== design/xsf_row.sv =====
module xsf_row #(
	parameter int MAX_WIDTH = 64
) (
	input  logic [MAX_WIDTH-1:0] row,
	input  logic [7:0]           start_column,
	input  logic [7:0]           sprite_bits,
	input  logic [6:0]           eff_width,
	output logic [MAX_WIDTH-1:0] new_row,
	output logic [MAX_WIDTH-1:0] masked_row,
	output logic                 collision
);

	logic [MAX_WIDTH-1:0]               col_mask;
	logic [xsf_pkg::SPRITE_PIXELS-1:0]  rev;
	logic [MAX_WIDTH-1:0]               placed;
	logic [MAX_WIDTH-1:0]               flip;

	// columns below the active width
	always_comb begin
		for (int k = 0; k < MAX_WIDTH; k++) begin
			col_mask[k] = 7'(k) < eff_width;
		end
	end

	// bit 7 is the leftmost pixel, so reverse to put it at the low column
	always_comb begin
		for (int i = 0; i < xsf_pkg::SPRITE_PIXELS; i++) begin
			rev[i] = sprite_bits[xsf_pkg::SPRITE_PIXELS-1-i];
		end
	end

	// shifting past the top clips, a start beyond the row gives nothing
	assign placed     = MAX_WIDTH'(rev) << start_column;
	assign flip       = placed & col_mask;
	assign collision  = |(row & flip);
	assign new_row    = row ^ flip;
	assign masked_row = row & col_mask;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int MAX_W = 64;
	localparam int MAX_H = 32;
	// the one opcode the block has no operation for
	localparam logic [1:0] OP_UNDEF = 2'd3;
	// cycles with no item moving on either side before the run is declared hung
	localparam int IDLE_LIMIT = 1000;
	localparam int PHASE_ITEMS = 138;
	// active windows for the first random phases, extremes included
	localparam logic [6:0] WIN_W [10] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8,
		7'd33, 7'd65, 7'd64, 7'd0, 7'd40};
	localparam logic [5:0] WIN_H [10] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd5,
		6'd17, 6'd33, 6'd0, 6'd32, 6'd63};

	// one result item, split into its fields
	typedef struct packed {
		logic        collision;
		logic        skipped;
		logic [63:0] row_pixels;
	} frame_result_t;

	// frame model plus the queue of results still owed by the block
	class frame_scoreboard;
		logic [63:0]   rows [MAX_H];
		logic [6:0]    width_reg;
		logic [5:0]    height_reg;
		frame_result_t pending [$];
		int            errors;

		function new();
			foreach (rows[i]) rows[i] = '0;
			width_reg = xsf_pkg::ACTIVE_WIDTH_RST;
			height_reg = xsf_pkg::ACTIVE_HEIGHT_RST;
			errors = 0;
		endfunction

		// apply one accepted operation to the frame and queue its result
		function void note_input(logic [1:0] op, logic [7:0] col, logic [7:0] row,
			logic [7:0] spr);
			int unsigned   w;
			int unsigned   h;
			int unsigned   c;
			logic [63:0]   line;
			frame_result_t r;
			w = (width_reg > MAX_W) ? MAX_W : width_reg;
			h = (height_reg > MAX_H) ? MAX_H : height_reg;
			r = '0;
			case (op)
				xsf_pkg::OP_DRAW: begin
					if (row >= h) begin
						r.skipped = 1'b1;
					end else begin
						line = rows[row];
						// bit 7 lands at the start column, clipped at the width
						for (int i = 0; i < xsf_pkg::SPRITE_PIXELS; i++) begin
							c = col + i;
							if (c < w && spr[7 - i]) begin
								if (line[c]) r.collision = 1'b1;
								line[c] = ~line[c];
							end
						end
						rows[row] = line;
					end
				end
				xsf_pkg::OP_CLEAR: begin
					foreach (rows[i]) rows[i] = '0;
				end
				xsf_pkg::OP_READ: begin
					if (row >= h)
						r.skipped = 1'b1;
					else if (w >= 64)
						r.row_pixels = rows[row];
					else
						r.row_pixels = rows[row] & ((64'd1 << w) - 64'd1);
				end
				default: ;
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(logic [63:0] pixels, logic [1:0] flags);
			frame_result_t want;
			if (pending.size() == 0) begin
				$error("result item with none expected: row_pixels %h flags %b", pixels, flags);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (flags[0] !== want.collision) begin
				$error("collision: expected %0d, got %0d", want.collision, flags[0]);
				errors++;
			end
			if (flags[1] !== want.skipped) begin
				$error("skipped: expected %0d, got %0d", want.skipped, flags[1]);
				errors++;
			end
			if (pixels !== want.row_pixels) begin
				$error("row_pixels: expected %h, got %h", want.row_pixels, pixels);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // start_column, row_index, sprite_bits
	logic [1:0]  s_tuser;  // opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;  // row_pixels
	logic [1:0]  m_tuser;  // collision, skipped
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [xsf_pkg::CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	frame_scoreboard sb;
	// when set, that side runs back to back with no idle cycles
	bit send_burst;
	bit take_burst;
	int idle_cycles;

	xor_sprite_framebuffer #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 2 ns clock
	always #1 clk = ~clk;

	// hang detection: any accepted item on either side restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// one item on the input side; called right after a rising edge
	// valid stays high across back-to-back items, dropped only for a gap
	task automatic send_item(input logic [1:0] op, input logic [7:0] col,
		input logic [7:0] row, input logic [7:0] spr);
		int gap;
		if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {spr, row, col};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, col, row, spr);
	endtask

	// stop sending and wait until every owed result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending.size() != 0);
	endtask

	// two-phase bus transfer, write lands at the access edge, then the bus goes idle
	task automatic cfg_access(input logic wr, input logic [xsf_pkg::CFG_ADDR_W-1:0] addr,
		input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// resize the active window while the block is idle, then read both back
	task automatic set_window(input logic [6:0] w, input logic [5:0] h);
		logic [31:0] rd;
		drain();
		// let the two-stage pipe settle fully
		repeat (4) @(posedge clk);
		cfg_access(1'b1, {xsf_pkg::REG_ACTIVE_WIDTH, 2'b00}, {25'd0, w}, rd);
		cfg_access(1'b1, {xsf_pkg::REG_ACTIVE_HEIGHT, 2'b00}, {26'd0, h}, rd);
		sb.width_reg = w;
		sb.height_reg = h;
		cfg_access(1'b0, {xsf_pkg::REG_ACTIVE_WIDTH, 2'b00}, '0, rd);
		if (rd[6:0] !== w) begin
			$error("active_width: expected %0d, got %0d", w, rd[6:0]);
			sb.errors++;
		end
		cfg_access(1'b0, {xsf_pkg::REG_ACTIVE_HEIGHT, 2'b00}, '0, rd);
		if (rd[5:0] !== h) begin
			$error("active_height: expected %0d, got %0d", h, rd[5:0]);
			sb.errors++;
		end
	endtask

	// random operation shaped around the current window
	task automatic send_random();
		int unsigned w;
		int unsigned h;
		int unsigned pick;
		logic [1:0]  op;
		logic [7:0]  col;
		logic [7:0]  row;
		w = (sb.width_reg > MAX_W) ? MAX_W : sb.width_reg;
		h = (sb.height_reg > MAX_H) ? MAX_H : sb.height_reg;
		pick = $urandom_range(0, 99);
		// mostly draws and reads, clears rare so the frame fills up
		if (pick < 60)
			op = xsf_pkg::OP_DRAW;
		else if (pick < 90)
			op = xsf_pkg::OP_READ;
		else if (pick < 93)
			op = xsf_pkg::OP_CLEAR;
		else
			op = OP_UNDEF;
		// start columns near the width hit the right-edge clipping
		if ($urandom_range(0, 4) != 0)
			col = 8'($urandom_range(0, w + 7));
		else
			col = 8'($urandom_range(0, 255));
		if (h > 0 && $urandom_range(0, 6) != 0)
			row = 8'($urandom_range(0, h - 1));
		else
			row = 8'($urandom_range(0, 255));
		send_item(op, col, row, 8'($urandom_range(0, 255)));
	endtask

	// result side: random stalls, each accepted item checked in order
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
			stall = take_burst ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata, m_tuser);
		end
	end

	initial begin
		sb = new();
		idle_cycles = 0;
		send_burst = 1'b0;
		take_burst = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= xsf_pkg::OP_DRAW;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at the reset window of 64 x 32
		send_item(xsf_pkg::OP_DRAW, 8'd0, 8'd0, 8'hFF);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd0, 8'h00);
		// outer pixels go dark again: collision
		send_item(xsf_pkg::OP_DRAW, 8'd0, 8'd0, 8'h81);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd0, 8'h00);
		// right edge clipping on the last row
		send_item(xsf_pkg::OP_DRAW, 8'd60, 8'd31, 8'hFF);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd31, 8'h00);
		send_item(xsf_pkg::OP_DRAW, 8'd63, 8'd31, 8'h80);
		send_item(xsf_pkg::OP_READ, 8'd255, 8'd31, 8'hFF);
		// start column at or past the width draws nothing
		send_item(xsf_pkg::OP_DRAW, 8'd64, 8'd5, 8'hFF);
		send_item(xsf_pkg::OP_DRAW, 8'd255, 8'd5, 8'hFF);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd5, 8'h00);
		// rows past the height are skipped
		send_item(xsf_pkg::OP_DRAW, 8'd0, 8'd32, 8'hFF);
		send_item(xsf_pkg::OP_DRAW, 8'd128, 8'd255, 8'hAA);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd32, 8'h00);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd255, 8'h00);
		// empty sprite, then the undefined opcode with every field high
		send_item(xsf_pkg::OP_DRAW, 8'd3, 8'd0, 8'h00);
		send_item(OP_UNDEF, 8'hFF, 8'hFF, 8'hFF);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd0, 8'h00);
		// clear ignores its fields and blanks everything
		send_item(xsf_pkg::OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd0, 8'h00);
		send_item(xsf_pkg::OP_READ, 8'd0, 8'd31, 8'h00);

		// random phases over a spread of windows, extremes included
		for (int p = 0; p < 12; p++) begin
			if (p < 10)
				set_window(WIN_W[p], WIN_H[p]);
			else
				set_window(7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// now and then hold the input until the pipe is empty
				if ($urandom_range(0, 79) == 0) drain();
				send_random();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
